### rtl/polyline_even_spacing_resampler_assert.svh
// Assertion macros used by the checker of the polyline resampler.
// No dependencies; included by the checker file.
`ifndef POLYLINE_EVEN_SPACING_RESAMPLER_ASSERT_SVH
`define POLYLINE_EVEN_SPACING_RESAMPLER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define PESR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pesr assertion failed: next-cycle property");

// Consequent must hold in the cycle after reset is seen.
`define PESR_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("pesr assertion failed: state after reset");

`endif

### rtl/pesr_pkg.sv
// Shared types and constants of the polyline even spacing resampler.
// No dependencies; imported by every module of the block.
package pesr_pkg;

   localparam int CoordWidth       = 32;
   localparam int RegWidth         = 24;
   localparam int LenInWidth       = 32;
   localparam int MagWidth         = CoordWidth + 1;
   localparam int SqWidth          = 2 * MagWidth;
   localparam int RootWidth        = MagWidth + 1;
   localparam int RadWidth         = 2 * RootWidth;
   localparam int BudgetWidth      = LenInWidth + 2;
   localparam int ProdWidth        = MagWidth + RegWidth;
   localparam int NumWidth         = ProdWidth + 1;
   localparam int DefaultMaxPoints = 64;
   localparam int QueueDepth       = 2;
   localparam int CsrIndexWidth    = 1;

   localparam logic [RegWidth-1:0] SpacingReset = RegWidth'(2560);
   localparam logic [RegWidth-1:0] OffsetReset  = '0;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SPACING = 1'b0,
      CSR_OFFSET  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_OPEN = 2'b01,
      CMD_WALK = 2'b10
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                  kind;
      logic                          last;
      logic                          long_enough;
      logic signed [CoordWidth-1:0]  x;
      logic signed [CoordWidth-1:0]  y;
      logic [LenInWidth-1:0]         total;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic [RegWidth-1:0] spacing;
      logic [RegWidth-1:0] offset;
   } cfg_type;

endpackage

### rtl/pesr_front.sv
// Front end: configuration registers, input acceptance and vertex classification.
// Depends on pesr_pkg; feeds pesr_queue.
module pesr_front import pesr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [RegWidth-1:0]          csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [CoordWidth-1:0] req_vertex_x,
   input  logic signed [CoordWidth-1:0] req_vertex_y,
   input  logic                         req_first_vertex,
   input  logic                         req_last_vertex,
   input  logic [LenInWidth-1:0]        req_line_length,
   input  logic                         queue_full,
   output logic                         push,
   output cmd_type                      push_cmd,
   output cfg_type                      cfg
);

   logic [RegWidth-1:0] spacing_ff, spacing_in;
   logic [RegWidth-1:0] offset_ff, offset_in;

   always_comb begin
      spacing_in = spacing_ff;
      offset_in  = offset_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPACING: spacing_in = csr_wdata;
            CSR_OFFSET:  offset_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SpacingReset;
         offset_ff  <= OffsetReset;
      end else begin
         spacing_ff <= spacing_in;
         offset_ff  <= offset_in;
      end
   end

   assign cfg.spacing = spacing_ff;
   assign cfg.offset  = offset_ff;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // A line shorter than the spacing is opened inactive and produces nothing.
   always_comb begin
      push_cmd.kind        = req_first_vertex ? CMD_OPEN : CMD_WALK;
      push_cmd.last        = req_last_vertex;
      push_cmd.long_enough = req_line_length >= LenInWidth'(spacing_ff);
      push_cmd.x           = req_vertex_x;
      push_cmd.y           = req_vertex_y;
      push_cmd.total       = req_line_length;
   end

endmodule

### rtl/pesr_queue.sv
// Short command queue between the front end and the segment walker.
// Depends on pesr_pkg.
module pesr_queue import pesr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cmd_type        push_cmd,
   input  logic           pop,
   output logic           full,
   output queue_head_type head
);

   localparam int PtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountW = $clog2(QueueDepth + 1);

   cmd_type            slot_ff [QueueDepth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic               do_pop;

   assign full   = count_ff == CountW'(QueueDepth);
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.cmd   = slot_ff[rd_ptr_ff];

endmodule

### rtl/pesr_isqrt.sv
// Integer square root, two radicand bits per cycle, one root bit per cycle.
// Depends on pesr_pkg; used by pesr_walk for segment lengths.
module pesr_isqrt import pesr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RadWidth-1:0]  radicand,
   output logic                 done,
   output logic [RootWidth-1:0] root
);

   localparam int CountW = $clog2(RootWidth + 1);

   logic [CountW-1:0]    count_ff, count_in;
   logic                 done_ff, done_in;
   logic [RadWidth-1:0]  rad_ff, rad_in;
   logic [RootWidth:0]   rem_ff, rem_in;
   logic [RootWidth-1:0] root_ff, root_in;
   logic [RootWidth+2:0] rem_sh;
   logic [RootWidth+2:0] trial;
   logic [RootWidth+2:0] diff;
   logic                 ge;

   assign rem_sh = {rem_ff, rad_ff[RadWidth-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign diff   = rem_sh - trial;
   assign ge     = rem_sh >= trial;

   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      if (start) begin
         count_in = CountW'(RootWidth);
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - CountW'(1);
         done_in  = count_ff == CountW'(1);
         rad_in   = {rad_ff[RadWidth-3:0], 2'b00};
         if (ge) begin
            rem_in  = diff[RootWidth:0];
            root_in = {root_ff[RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RootWidth:0];
            root_in = {root_ff[RootWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### rtl/pesr_div.sv
// Restoring divider, one quotient bit per cycle, x and y lanes sharing one divisor.
// Depends on pesr_pkg; used by pesr_walk for point interpolation.
module pesr_div import pesr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NumWidth-1:0]  dividend_x,
   input  logic [NumWidth-1:0]  dividend_y,
   input  logic [RootWidth-1:0] divisor,
   output logic                 done,
   output logic [NumWidth-1:0]  quot_x,
   output logic [NumWidth-1:0]  quot_y
);

   localparam int CountW = $clog2(NumWidth + 1);

   logic [CountW-1:0]    count_ff, count_in;
   logic                 done_ff, done_in;
   logic [NumWidth-1:0]  numx_ff, numx_in, numy_ff, numy_in;
   logic [RootWidth-1:0] remx_ff, remx_in, remy_ff, remy_in;
   logic [RootWidth-1:0] div_ff, div_in;
   logic [RootWidth:0]   shx, shy, diffx, diffy;
   logic                 gex, gey;

   assign shx   = {remx_ff, numx_ff[NumWidth-1]};
   assign shy   = {remy_ff, numy_ff[NumWidth-1]};
   assign gex   = shx >= {1'b0, div_ff};
   assign gey   = shy >= {1'b0, div_ff};
   assign diffx = shx - {1'b0, div_ff};
   assign diffy = shy - {1'b0, div_ff};

   always_comb begin
      count_in = count_ff;
      done_in  = 1'b0;
      numx_in  = numx_ff;
      numy_in  = numy_ff;
      remx_in  = remx_ff;
      remy_in  = remy_ff;
      div_in   = div_ff;
      if (start) begin
         count_in = CountW'(NumWidth);
         numx_in  = dividend_x;
         numy_in  = dividend_y;
         remx_in  = '0;
         remy_in  = '0;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - CountW'(1);
         done_in  = count_ff == CountW'(1);
         remx_in  = gex ? diffx[RootWidth-1:0] : shx[RootWidth-1:0];
         remy_in  = gey ? diffy[RootWidth-1:0] : shy[RootWidth-1:0];
         numx_in  = {numx_ff[NumWidth-2:0], gex};
         numy_in  = {numy_ff[NumWidth-2:0], gey};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      numx_ff <= numx_in;
      numy_ff <= numy_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      div_ff  <= div_in;
   end

   assign done   = done_ff;
   assign quot_x = numx_ff;
   assign quot_y = numy_ff;

endmodule

### rtl/pesr_walk.sv
// Back end: walks segments, computes points into a buffer, then plays them out.
// Depends on pesr_pkg, pesr_isqrt and pesr_div.
module pesr_walk import pesr_pkg::*; #(
   parameter int MaxPoints = DefaultMaxPoints
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  queue_head_type               head,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [CoordWidth-1:0] rsp_point_x,
   output logic signed [CoordWidth-1:0] rsp_point_y,
   output logic                         rsp_last_of_run,
   output logic                         rsp_capped
);

   localparam int CntW = $clog2(MaxPoints + 1);
   localparam int IdxW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b000000000001,
      ST_DIFF    = 12'b000000000010,
      ST_SQUARE  = 12'b000000000100,
      ST_ROOT_GO = 12'b000000001000,
      ST_ROOT    = 12'b000000010000,
      ST_DECIDE  = 12'b000000100000,
      ST_MUL     = 12'b000001000000,
      ST_DIV_GO  = 12'b000010000000,
      ST_DIV     = 12'b000100000000,
      ST_FINISH  = 12'b001000000000,
      ST_READ    = 12'b010000000000,
      ST_LOAD    = 12'b100000000000
   } walk_state_type;

   walk_state_type state_ff, state_in;

   logic                         active_ff, active_in;
   logic                         have_start_ff, have_start_in;
   logic signed [CoordWidth-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CoordWidth-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [RegWidth-1:0]          dtn_ff, dtn_in;
   logic [BudgetWidth-1:0]       budget_ff, budget_in;
   logic                         last_ff, last_in;
   logic [CntW-1:0]              n_ff, n_in;
   logic                         capped_ff, capped_in;
   logic [MagWidth-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [SqWidth-1:0]           sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RootWidth-1:0]         len_ff, len_in;
   logic [ProdWidth-1:0]         prodx_ff, prodx_in, prody_ff, prody_in;
   logic [IdxW-1:0]              rd_idx_ff, rd_idx_in;
   logic [2*CoordWidth-1:0]      rd_data_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [CoordWidth-1:0]        out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_capped_ff, out_capped_in;

   logic [2*CoordWidth-1:0]      buf_mem [MaxPoints];

   logic [MagWidth-1:0]          magx, magy;
   logic [SqWidth-1:0]           sqx, sqy;
   logic [ProdWidth-1:0]         prodx, prody;
   logic                         root_go, root_done;
   logic [RootWidth-1:0]         root;
   logic                         div_go, div_done;
   logic [NumWidth-1:0]          quot_x, quot_y;
   logic [MagWidth-1:0]          cx, cy;
   logic [CoordWidth-1:0]        ix, iy;
   logic                         emit;
   logic [CoordWidth-1:0]        pt_x, pt_y;
   logic                         out_free;

   assign magx  = dx_ff[MagWidth-1] ? MagWidth'(-dx_ff) : dx_ff;
   assign magy  = dy_ff[MagWidth-1] ? MagWidth'(-dy_ff) : dy_ff;
   assign sqx   = magx * magx;
   assign sqy   = magy * magy;
   assign prodx = magx * dtn_ff;
   assign prody = magy * dtn_ff;

   assign root_go = state_ff == ST_ROOT_GO;
   assign div_go  = state_ff == ST_DIV_GO;

   pesr_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_go),
      .radicand (RadWidth'(sqx_ff) + RadWidth'(sqy_ff)),
      .done     (root_done),
      .root     (root)
   );

   pesr_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_go),
      .dividend_x (NumWidth'(prodx_ff) + NumWidth'(len_ff >> 1)),
      .dividend_y (NumWidth'(prody_ff) + NumWidth'(len_ff >> 1)),
      .divisor    (len_ff),
      .done       (div_done),
      .quot_x     (quot_x),
      .quot_y     (quot_y)
   );

   // Rounded quotient never passes the segment end; clamp to the difference anyway.
   assign cx = (quot_x > NumWidth'(magx)) ? magx : quot_x[MagWidth-1:0];
   assign cy = (quot_y > NumWidth'(magy)) ? magy : quot_y[MagWidth-1:0];
   assign ix = dx_ff[MagWidth-1] ? CoordWidth'({sx_ff[CoordWidth-1], sx_ff} - cx)
                                 : CoordWidth'({sx_ff[CoordWidth-1], sx_ff} + cx);
   assign iy = dy_ff[MagWidth-1] ? CoordWidth'({sy_ff[CoordWidth-1], sy_ff} - cy)
                                 : CoordWidth'({sy_ff[CoordWidth-1], sy_ff} + cy);

   assign out_free = !out_valid_ff || rsp_ready;
   assign pop      = (state_ff == ST_IDLE) && head.valid;

   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      have_start_in = have_start_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      dtn_in        = dtn_ff;
      budget_in     = budget_ff;
      last_in       = last_ff;
      n_in          = n_ff;
      capped_in     = capped_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      len_in        = len_ff;
      prodx_in      = prodx_ff;
      prody_in      = prody_ff;
      rd_idx_in     = rd_idx_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_last_in   = out_last_ff;
      out_capped_in = out_capped_ff;
      emit          = 1'b0;
      pt_x          = sx_ff;
      pt_y          = sy_ff;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (head.cmd.kind == CMD_OPEN) begin
                  sx_in         = head.cmd.x;
                  sy_in         = head.cmd.y;
                  budget_in     = BudgetWidth'(head.cmd.total);
                  dtn_in        = cfg.offset;
                  active_in     = head.cmd.long_enough && !head.cmd.last;
                  have_start_in = !head.cmd.last;
               end else if (active_ff && have_start_ff) begin
                  vx_in     = head.cmd.x;
                  vy_in     = head.cmd.y;
                  last_in   = head.cmd.last;
                  n_in      = '0;
                  capped_in = 1'b0;
                  state_in  = ST_DIFF;
               end else if (head.cmd.last) begin
                  active_in     = 1'b0;
                  have_start_in = 1'b0;
               end
            end
         end
         ST_DIFF: begin
            if (budget_ff[BudgetWidth-1]) begin
               state_in = ST_FINISH;
            end else begin
               dx_in    = {vx_ff[CoordWidth-1], vx_ff} - {sx_ff[CoordWidth-1], sx_ff};
               dy_in    = {vy_ff[CoordWidth-1], vy_ff} - {sy_ff[CoordWidth-1], sy_ff};
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sqx_in   = sqx;
            sqy_in   = sqy;
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               len_in   = root;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (len_ff < RootWidth'(dtn_ff)) begin
               dtn_in   = dtn_ff - len_ff[RegWidth-1:0];
               sx_in    = vx_ff;
               sy_in    = vy_ff;
               state_in = ST_FINISH;
            end else if (n_ff == CntW'(MaxPoints)) begin
               // Further points are dropped; the walk resumes at this vertex.
               capped_in = 1'b1;
               sx_in     = vx_ff;
               sy_in     = vy_ff;
               state_in  = ST_FINISH;
            end else if (len_ff == '0) begin
               // Zero-length segment with nothing left to cover: emit its start.
               emit     = 1'b1;
               state_in = ST_DIFF;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prodx_in = prodx;
            prody_in = prody;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               emit     = 1'b1;
               pt_x     = ix;
               pt_y     = iy;
               state_in = ST_DIFF;
            end
         end
         ST_FINISH: begin
            if (last_ff) begin
               active_in     = 1'b0;
               have_start_in = 1'b0;
            end
            rd_idx_in = '0;
            state_in  = (n_ff == '0) ? ST_IDLE : ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_x_in      = rd_data_ff[2*CoordWidth-1:CoordWidth];
               out_y_in      = rd_data_ff[CoordWidth-1:0];
               out_last_in   = (CntW'(rd_idx_ff) + CntW'(1)) == n_ff;
               out_capped_in = capped_ff;
               if ((CntW'(rd_idx_ff) + CntW'(1)) == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + IdxW'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         sx_in     = pt_x;
         sy_in     = pt_y;
         budget_in = budget_ff - BudgetWidth'(cfg.spacing);
         dtn_in    = cfg.spacing;
         n_in      = n_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= 1'b0;
         have_start_ff <= 1'b0;
         sx_ff         <= '0;
         sy_ff         <= '0;
         dtn_ff        <= '0;
         budget_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         have_start_ff <= have_start_in;
         sx_ff         <= sx_in;
         sy_ff         <= sy_in;
         dtn_ff        <= dtn_in;
         budget_ff     <= budget_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      last_ff       <= last_in;
      n_ff          <= n_in;
      capped_ff     <= capped_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      len_ff        <= len_in;
      prodx_ff      <= prodx_in;
      prody_ff      <= prody_in;
      rd_idx_ff     <= rd_idx_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_last_ff   <= out_last_in;
      out_capped_ff <= out_capped_in;
   end

   // Point buffer: one write per computed point, one registered read per playout.
   always_ff @(posedge clock) begin
      if (emit) begin
         buf_mem[n_ff[IdxW-1:0]] <= {pt_x, pt_y};
      end
      if (state_ff == ST_READ) begin
         rd_data_ff <= buf_mem[rd_idx_ff];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_point_x     = out_x_ff;
   assign rsp_point_y     = out_y_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_capped      = out_capped_ff;

endmodule

### rtl/polyline_even_spacing_resampler.sv
// Top level of the polyline even spacing resampler: front end, queue, segment walker.
// Depends on pesr_pkg, pesr_front, pesr_queue and pesr_walk.
//
//   Channel   Ports      Carries
//   input     req_*      one polyline vertex per transaction
//   result    rsp_*      one resampled point per transaction
//   config    csr_*      register writes, taken in the cycle of csr_wr_en
//
// A vertex that opens a line or is ignored is handled in the idle state; a
// walked vertex with no point takes a square root, or a budget check once the
// budget is spent. An interpolated point costs a square root and a divide; each
// point is then played out from the buffer through a registered read.
// Reset is synchronous; there is no clearing pass.
// A stalled result holds the walker only; the front end keeps filling the queue.
module polyline_even_spacing_resampler import pesr_pkg::*; #(
   parameter int MAX_POINTS_PER_VERTEX = DefaultMaxPoints
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [CsrIndexWidth-1:0]     csr_index,
   input  logic [RegWidth-1:0]          csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [CoordWidth-1:0] req_vertex_x,
   input  logic signed [CoordWidth-1:0] req_vertex_y,
   input  logic                         req_first_vertex,
   input  logic                         req_last_vertex,
   input  logic [LenInWidth-1:0]        req_line_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [CoordWidth-1:0] rsp_point_x,
   output logic signed [CoordWidth-1:0] rsp_point_y,
   output logic                         rsp_last_of_run,
   output logic                         rsp_capped
);

   logic           queue_full;
   logic           push;
   cmd_type        push_cmd;
   cfg_type        cfg;
   logic           pop;
   queue_head_type head;

   pesr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .req_line_length  (req_line_length),
      .queue_full       (queue_full),
      .push             (push),
      .push_cmd         (push_cmd),
      .cfg              (cfg)
   );

   pesr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   pesr_walk #(
      .MaxPoints (MAX_POINTS_PER_VERTEX)
   ) u_walk (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_capped      (rsp_capped)
   );

endmodule

### rtl/pesr_checker.sv
// Port-level checker for the polyline resampler, bound to the top level.
// Depends on pesr_pkg and polyline_even_spacing_resampler_assert.svh.
`include "polyline_even_spacing_resampler_assert.svh"

module pesr_checker import pesr_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [CoordWidth-1:0] rsp_point_x,
   input logic signed [CoordWidth-1:0] rsp_point_y,
   input logic                         rsp_last_of_run,
   input logic                         rsp_capped
);

   logic                      rsp_stall;
   logic [2*CoordWidth+1:0]   rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_point_x, rsp_point_y, rsp_last_of_run, rsp_capped};

   `PESR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))
   `PESR_ASSERT_AFTER_RESET(a_rsp_quiet_after_reset, clock, reset, !rsp_valid)
   `PESR_ASSERT_AFTER_RESET(a_req_open_after_reset, clock, reset, req_ready)

endmodule

bind polyline_even_spacing_resampler pesr_checker u_pesr_checker (.*);
